// File: rtl/core/assert_macros.svh
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/core/stbs_pkg.sv
package stbs_pkg;

   localparam int POS_W      = 9;
   localparam int VAL_W      = 32;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_SEARCH = 1'b1;

   localparam logic [CSR_ADDR_W-1:0] REG_COUNT_ADDR = 2'd0;

   // request from the sequencer to the store, positions counted from 1
   typedef struct packed {
      logic                    wr_en;
      logic [POS_W-1:0]        wr_pos;
      logic signed [VAL_W-1:0] wr_data;
      logic                    rd_en;
      logic [POS_W-1:0]        rd_pos;
   } mem_req_type;

endpackage

// File: rtl/core/stbs_chan_if.sv
interface stbs_req_if import stbs_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    func;
   logic [POS_W-1:0]        position;
   logic signed [VAL_W-1:0] entry_value;
   logic signed [VAL_W-1:0] search_key;

   modport source (output valid, output func, output position, output entry_value,
                   output search_key, input ready);
   modport sink   (input valid, input func, input position, input entry_value,
                   input search_key, output ready);
endinterface

interface stbs_rsp_if import stbs_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             found;
   logic [POS_W-1:0] match_position;

   modport source (output valid, output found, output match_position, input ready);
   modport sink   (input valid, input found, input match_position, output ready);
endinterface

// File: rtl/core/sorted_table_binary_search.sv
// sorted table binary search
// req_bus carries one beat per item: func low writes entry_value at position
// (1..DEPTH, other positions are dropped), func high searches for search_key.
// rsp_bus carries one beat per search: found and the leftmost matching
// position, or found low with match_position zero. loads give no beat.
// the csr port holds count_in_use at byte address 0 (writes take effect at the
// access cycle, pready is tied high); counts above DEPTH act as DEPTH.
// a search makes one store read and one signed compare per halving step in a
// shared midpoint/compare loop, then an equality check on the last read; an
// empty table skips the store reads and answers with found low.
// req_bus.ready is high only while no search is in flight.
// the result sits in an output register; a stalled rsp_bus holds it, loads and
// one further search are still taken, and that search waits at its final check
// until the register frees.
// synchronous reset clears count_in_use, the sequencer and the output valid;
// store contents are undefined until written.
module sorted_table_binary_search import stbs_pkg::*; #(
   parameter int DEPTH = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   stbs_req_if.sink              req_bus,
   stbs_rsp_if.source            rsp_bus,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [POS_W-1:0]        count_in_use;
   mem_req_type             mem_req;
   logic signed [VAL_W-1:0] rd_data;

   stbs_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .count_in_use (count_in_use)
   );

   stbs_store #(.DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   stbs_seq #(.DEPTH(DEPTH)) u_seq (
      .clock        (clock),
      .reset        (reset),
      .count_in_use (count_in_use),
      .req_bus      (req_bus),
      .rsp_bus      (rsp_bus),
      .mem_req      (mem_req),
      .rd_data      (rd_data)
   );

endmodule

// File: rtl/core/stbs_csr.sv
module stbs_csr import stbs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [POS_W-1:0]      count_in_use
);

   logic [POS_W-1:0] count_ff;
   logic [POS_W-1:0] count_in;
   logic             wr_hit;

   assign csr_pready = 1'b1;
   assign wr_hit = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr == REG_COUNT_ADDR);

   always_comb begin
      count_in = count_ff;
      if (wr_hit) begin
         count_in = csr_pwdata[POS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == REG_COUNT_ADDR) begin
         csr_prdata = CSR_DATA_W'(count_ff);
      end
   end

   assign count_in_use = count_ff;

endmodule

// File: rtl/core/stbs_store.sv
module stbs_store import stbs_pkg::*; #(
   parameter int DEPTH = 256
) (
   input  logic                    clock,
   input  mem_req_type             mem_req,
   output logic signed [VAL_W-1:0] rd_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic signed [VAL_W-1:0] mem [DEPTH];
   logic signed [VAL_W-1:0] rd_data_ff;
   logic [AW-1:0]           wr_addr;
   logic [AW-1:0]           rd_addr;

   // positions start at 1, entries at 0
   assign wr_addr = AW'(POS_W'(mem_req.wr_pos - POS_W'(1)));
   assign rd_addr = AW'(POS_W'(mem_req.rd_pos - POS_W'(1)));

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[wr_addr] <= mem_req.wr_data;
      end
   end

   // read data holds while no read is issued
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/stbs_seq.sv
module stbs_seq import stbs_pkg::*; #(
   parameter int DEPTH = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [POS_W-1:0]        count_in_use,
   stbs_req_if.sink                req_bus,
   stbs_rsp_if.source              rsp_bus,
   output mem_req_type             mem_req,
   input  logic signed [VAL_W-1:0] rd_data
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_FINAL  = 2'd2;

   logic [1:0]              state_ff, state_in;
   logic [POS_W-1:0]        left_ff, left_in;
   logic [POS_W-1:0]        right_ff, right_in;
   logic [POS_W-1:0]        mid_ff, mid_in;
   logic signed [VAL_W-1:0] key_ff, key_in;
   logic                    empty_ff, empty_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    found_ff, found_in;
   logic [POS_W-1:0]        match_ff, match_in;

   logic             accept;
   logic [POS_W-1:0] n_lim;
   logic             in_range;
   logic             less;
   logic             slot_free;
   logic [POS_W-1:0] step_left;
   logic [POS_W-1:0] step_right;
   logic [POS_W:0]   mid_sum;
   logic [POS_W-1:0] mid_pos;
   logic             narrowing;
   logic             hit;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept = req_bus.valid && req_bus.ready;

   assign n_lim = (32'(count_in_use) > DEPTH) ? POS_W'(DEPTH) : count_in_use;
   assign in_range = (req_bus.position != '0) && (32'(req_bus.position) <= DEPTH);

   assign less = rd_data < key_ff;
   assign slot_free = !rsp_valid_ff || rsp_bus.ready;
   assign hit = !empty_ff && (rd_data == key_ff);

   // bounds fed to the shared midpoint unit: start of a search or one halving step
   always_comb begin
      if (state_ff == ST_IDLE) begin
         step_left  = POS_W'(1);
         step_right = n_lim;
      end else if (less) begin
         step_left  = POS_W'(mid_ff + POS_W'(1));
         step_right = right_ff;
      end else begin
         step_left  = left_ff;
         step_right = mid_ff;
      end
   end

   assign mid_sum   = {1'b0, step_left} + {1'b0, step_right};
   assign mid_pos   = mid_sum[POS_W:1];
   assign narrowing = step_left < step_right;

   always_comb begin
      state_in     = state_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      mid_in       = mid_ff;
      key_in       = key_ff;
      empty_in     = empty_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      found_in     = found_ff;
      match_in     = match_ff;
      mem_req      = '0;
      mem_req.wr_pos  = req_bus.position;
      mem_req.wr_data = req_bus.entry_value;
      mem_req.rd_pos  = narrowing ? mid_pos : step_right;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_bus.func == FUNC_LOAD)) begin
               mem_req.wr_en = in_range;
            end else if (accept) begin
               key_in   = req_bus.search_key;
               left_in  = step_left;
               right_in = step_right;
               mid_in   = mid_pos;
               if (n_lim == '0) begin
                  empty_in = 1'b1;
                  state_in = ST_FINAL;
               end else begin
                  empty_in      = 1'b0;
                  mem_req.rd_en = 1'b1;
                  state_in      = narrowing ? ST_SEARCH : ST_FINAL;
               end
            end
         end
         ST_SEARCH: begin
            left_in       = step_left;
            right_in      = step_right;
            mid_in        = mid_pos;
            mem_req.rd_en = 1'b1;
            // once the range has closed the read fetches the final position
            state_in      = narrowing ? ST_SEARCH : ST_FINAL;
         end
         ST_FINAL: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               found_in     = hit;
               match_in     = hit ? right_ff : '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff  <= left_in;
      right_ff <= right_in;
      mid_ff   <= mid_in;
      key_ff   <= key_in;
      empty_ff <= empty_in;
      found_ff <= found_in;
      match_ff <= match_in;
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.found          = found_ff;
   assign rsp_bus.match_position = match_ff;

endmodule

// File: rtl/core/stbs_chk.sv
`include "assert_macros.svh"

module stbs_chk import stbs_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             req_func,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic             rsp_found,
   input logic [POS_W-1:0] rsp_match_position
);

   // a stalled result beat keeps its contents
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                rsp_valid && $stable(rsp_found) && $stable(rsp_match_position))

   // a miss always reports position zero
   `ASSERT_IMPLY(a_miss_zero, clock, reset, rsp_valid && !rsp_found,
                 rsp_match_position == '0)

   // a hit never reports position zero
   `ASSERT_IMPLY(a_hit_nonzero, clock, reset, rsp_valid && rsp_found,
                 rsp_match_position != '0)

   // an accepted search beat is followed by the input being closed
   `ASSERT_NEXT(a_search_busy, clock, reset,
                req_valid && req_ready && (req_func == FUNC_SEARCH), !req_ready)

endmodule

bind sorted_table_binary_search stbs_chk u_chk (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_bus.valid),
   .req_ready          (req_bus.ready),
   .req_func           (req_bus.func),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_found          (rsp_bus.found),
   .rsp_match_position (rsp_bus.match_position)
);
